@@ src/bht_pkg.sv @@
`timescale 1ns / 1ps

package bht_pkg;

    localparam int KEY_W      = 64;
    localparam int TAG_W      = 32;
    localparam int INFO_W     = 32;
    localparam int MOVE_W     = 22;
    localparam int DEPTH_W    = 6;
    localparam int KIND_W     = 4;
    localparam int SCORE_IO_W = 16;
    localparam int WAYS       = 4;
    localparam int WAY_W      = 2;
    localparam int DEPTH_LSB  = 22;
    localparam int KIND_LSB   = 28;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [KIND_W-1:0] EXACT_KIND_RESET = 4'd1;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_STORE  = 1'b1
    } t_op;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

@@ src/bht_front.sv @@
`timescale 1ns / 1ps

module bht_front
    import bht_pkg::*;
#(
    parameter int INDEX_BITS = 12,
    parameter int SCORE_BITS = 16,
    parameter int REQ_W      = 1 + INDEX_BITS + TAG_W + INFO_W + SCORE_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_operation,
    input  logic [KEY_W-1:0]             i_position_key,
    input  logic [MOVE_W-1:0]            i_move_code,
    input  logic [DEPTH_W-1:0]           i_search_depth,
    input  logic [KIND_W-1:0]            i_node_kind,
    input  logic signed [SCORE_IO_W-1:0] i_eval_score,
    input  logic [KIND_W-1:0]            i_exact_kind,
    input  t_back_status                 i_stat,
    output logic                         o_req_valid,
    output logic [REQ_W-1:0]             o_req_data,
    input  logic                         i_req_ready
);

    typedef struct packed {
        t_op                     op;
        logic [INDEX_BITS-1:0]   idx;
        logic [TAG_W-1:0]        tag;
        logic [INFO_W-1:0]       info;
        logic [SCORE_BITS-1:0]   score;
        logic                    new_exact;
    } t_req;

    t_req                r_req;
    t_req                n_req;
    logic                r_valid;
    logic signed [31:0]  score_ext;
    logic                accept;

    assign o_ready = (!r_valid || i_req_ready) && !i_stat.clearing;
    assign accept  = i_valid && o_ready;

    always_comb begin
        score_ext       = 32'(i_eval_score);
        n_req.op        = t_op'(i_operation);
        n_req.idx       = i_position_key[INDEX_BITS-1:0];
        n_req.tag       = i_position_key[KEY_W-1:KEY_W-TAG_W];
        n_req.info      = {i_node_kind, i_search_depth, i_move_code};
        n_req.score     = score_ext[SCORE_BITS-1:0];
        n_req.new_exact = (i_node_kind == i_exact_kind);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_req   <= n_req;
            end else if (r_valid && i_req_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_req_valid = r_valid;
    assign o_req_data  = REQ_W'(r_req);

endmodule

@@ src/bht_queue.sv @@
`timescale 1ns / 1ps

module bht_queue
    import bht_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output logic [DATA_W-1:0] o_pop_data,
    input  logic              i_pop
);

    logic [DATA_W-1:0]  r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_slot[r_wr_ptr] <= i_push_data;
                r_wr_ptr         <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/bht_back.sv @@
`timescale 1ns / 1ps

module bht_back
    import bht_pkg::*;
#(
    parameter int INDEX_BITS = 12,
    parameter int SCORE_BITS = 16,
    parameter int REQ_W      = 1 + INDEX_BITS + TAG_W + INFO_W + SCORE_BITS + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [KIND_W-1:0]            i_exact_kind,
    input  logic                         i_req_valid,
    input  logic [REQ_W-1:0]             i_req_data,
    output logic                         o_req_pop,
    output t_back_status                 o_stat,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    output logic [MOVE_W-1:0]            o_found_move,
    output logic [DEPTH_W-1:0]           o_found_depth,
    output logic [KIND_W-1:0]            o_found_kind,
    output logic signed [SCORE_IO_W-1:0] o_found_score,
    output logic                         o_written,
    output logic [WAY_W-1:0]             o_way_used
);

    localparam int BUCKETS = 2 ** INDEX_BITS;

    typedef struct packed {
        t_op                     op;
        logic [INDEX_BITS-1:0]   idx;
        logic [TAG_W-1:0]        tag;
        logic [INFO_W-1:0]       info;
        logic [SCORE_BITS-1:0]   score;
        logic                    new_exact;
    } t_req;

    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic [INFO_W-1:0]     info;
        logic [SCORE_BITS-1:0] score;
    } t_entry;

    typedef t_entry [WAYS-1:0] t_row;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    t_state                r_state;
    logic [INDEX_BITS-1:0] r_clr_idx;
    t_req                  r_req;
    t_req                  q_req;
    t_row                  r_mem [BUCKETS];
    t_row                  r_rd_row;
    t_row                  n_row;
    logic                  r_out_valid;
    logic                  pop;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_wa;
    t_row                  mem_wd;

    logic [WAYS-1:0]       match;
    logic                  hit_any;
    logic [WAY_W-1:0]      hit_way;
    logic                  free_any;
    logic [WAY_W-1:0]      free_way;
    logic                  rep_any;
    logic [WAY_W-1:0]      rep_way;
    logic [DEPTH_W:0]      best_depth;
    logic                  n_written;
    logic [WAY_W-1:0]      n_way;
    t_entry                hit_entry;
    logic signed [31:0]    hit_score;

    assign q_req     = t_req'(i_req_data);
    assign pop       = (r_state == S_IDLE) && i_req_valid && (!r_out_valid || i_ready);
    assign o_req_pop = pop;
    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_valid   = r_out_valid;

    always_comb begin
        hit_any    = 1'b0;
        hit_way    = '0;
        free_any   = 1'b0;
        free_way   = '0;
        rep_any    = 1'b0;
        rep_way    = '0;
        best_depth = {1'b1, {DEPTH_W{1'b0}}};
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = (r_rd_row[w].tag == r_req.tag);
            if (match[w]) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (match[w] || (r_rd_row[w].info == '0)) begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if ((r_rd_row[w].info[KIND_LSB +: KIND_W] != i_exact_kind)
                && ({1'b0, r_rd_row[w].info[DEPTH_LSB +: DEPTH_W]} < best_depth)) begin
                best_depth = {1'b0, r_rd_row[w].info[DEPTH_LSB +: DEPTH_W]};
                rep_way    = WAY_W'(w);
                rep_any    = 1'b1;
            end
        end

        priority if (free_any) begin
            n_written = 1'b1;
            n_way     = free_way;
        end else if (rep_any) begin
            n_written = 1'b1;
            n_way     = rep_way;
        end else if (r_req.new_exact) begin
            n_written = 1'b1;
            n_way     = '0;
        end else begin
            n_written = 1'b0;
            n_way     = '0;
        end

        n_row              = r_rd_row;
        n_row[n_way].tag   = r_req.tag;
        n_row[n_way].info  = r_req.info;
        n_row[n_way].score = r_req.score;

        hit_entry = r_rd_row[hit_way];
        hit_score = 32'(signed'(hit_entry.score));
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_req.idx;
        mem_wd = n_row;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_idx;
            mem_wd = '0;
        end else if ((r_state == S_EVAL) && (r_req.op == OP_STORE) && n_written) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (pop) begin
            r_rd_row <= r_mem[q_req.idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (&r_clr_idx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        r_req   <= q_req;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_out_valid <= 1'b1;
                    if (r_req.op == OP_LOOKUP) begin
                        o_hit         <= hit_any;
                        o_found_move  <= hit_any ? hit_entry.info[MOVE_W-1:0] : '0;
                        o_found_depth <= hit_any ? hit_entry.info[DEPTH_LSB +: DEPTH_W] : '0;
                        o_found_kind  <= hit_any ? hit_entry.info[KIND_LSB +: KIND_W] : '0;
                        o_found_score <= hit_any ? hit_score[SCORE_IO_W-1:0] : '0;
                        o_written     <= 1'b0;
                        o_way_used    <= hit_any ? hit_way : '0;
                    end else begin
                        o_hit         <= 1'b0;
                        o_found_move  <= '0;
                        o_found_depth <= '0;
                        o_found_kind  <= '0;
                        o_found_score <= '0;
                        o_written     <= n_written;
                        o_way_used    <= n_way;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_eval_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> !r_out_valid)
        else $error("result register busy when a bucket is evaluated");

    a_eval_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |=> (r_state == S_IDLE))
        else $error("evaluation did not return to idle");

    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_req_pop)
        else $error("request popped during the clearing pass");

    a_hit_xor_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(o_hit && o_written))
        else $error("result shows both a hit and a write");

endmodule

@@ src/bucketed_hash_table_with_replacement_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake                    | Word
// ---------+------------------------------+--------------------------------------------
// input    | i_valid / o_ready            | operation, key, move, depth, kind, score
// output   | o_valid / i_ready            | hit, found fields, written, way_used
// config   | i_cfg_we (no wait)           | i_cfg_data, exact node type
//
// Back end: a registered bucket read, then the hit check or, for a store, the replacement
// decision with its write-back, both on the single-port bucket memory; one word at a time.
// Words pass the front register, a queue slot and the bucket read register to the output.
// After reset a clearing pass zeroes all 2**INDEX_BITS buckets, one bucket per cycle, and
// o_ready stays low until it ends. The front register and a two-word queue keep accepting
// words while a result waits on i_ready, until both are full.
module bucketed_hash_table_with_replacement_unit
    import bht_pkg::*;
#(
    parameter int INDEX_BITS = 12,
    parameter int SCORE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_operation,
    input  logic [KEY_W-1:0]             i_position_key,
    input  logic [MOVE_W-1:0]            i_move_code,
    input  logic [DEPTH_W-1:0]           i_search_depth,
    input  logic [KIND_W-1:0]            i_node_kind,
    input  logic signed [SCORE_IO_W-1:0] i_eval_score,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_hit,
    output logic [MOVE_W-1:0]            o_found_move,
    output logic [DEPTH_W-1:0]           o_found_depth,
    output logic [KIND_W-1:0]            o_found_kind,
    output logic signed [SCORE_IO_W-1:0] o_found_score,
    output logic                         o_written,
    output logic [WAY_W-1:0]             o_way_used,
    input  logic                         i_cfg_we,
    input  logic [KIND_W-1:0]            i_cfg_data
);

    localparam int REQ_W = 1 + INDEX_BITS + TAG_W + INFO_W + SCORE_BITS + 1;

    logic [KIND_W-1:0] r_exact_kind;
    t_back_status      stat;
    logic              front_valid;
    logic [REQ_W-1:0]  front_data;
    logic              queue_ready;
    logic              queue_valid;
    logic [REQ_W-1:0]  queue_data;
    logic              queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_kind <= EXACT_KIND_RESET;
        end else if (i_cfg_we) begin
            r_exact_kind <= i_cfg_data;
        end
    end

    bht_front #(
        .INDEX_BITS (INDEX_BITS),
        .SCORE_BITS (SCORE_BITS),
        .REQ_W      (REQ_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_position_key (i_position_key),
        .i_move_code    (i_move_code),
        .i_search_depth (i_search_depth),
        .i_node_kind    (i_node_kind),
        .i_eval_score   (i_eval_score),
        .i_exact_kind   (r_exact_kind),
        .i_stat         (stat),
        .o_req_valid    (front_valid),
        .o_req_data     (front_data),
        .i_req_ready    (queue_ready)
    );

    bht_queue #(
        .DATA_W (REQ_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_data),
        .o_push_ready (queue_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_data   (queue_data),
        .i_pop        (queue_pop)
    );

    bht_back #(
        .INDEX_BITS (INDEX_BITS),
        .SCORE_BITS (SCORE_BITS),
        .REQ_W      (REQ_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_exact_kind  (r_exact_kind),
        .i_req_valid   (queue_valid),
        .i_req_data    (queue_data),
        .o_req_pop     (queue_pop),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_found_move  (o_found_move),
        .o_found_depth (o_found_depth),
        .o_found_kind  (o_found_kind),
        .o_found_score (o_found_score),
        .o_written     (o_written),
        .o_way_used    (o_way_used)
    );

endmodule
